FILE: hw/rtl/rkc_pkg.sv
`default_nettype none

package rkc_pkg;

    // Frame geometry
    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;

    // Counter and index widths
    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 3);
    localparam int OROW_W = $clog2(IMAGE_HEIGHT);
    localparam int YW     = $clog2(IMAGE_HEIGHT + 5);
    localparam int XW     = $clog2(IMAGE_WIDTH + 5);

    // Pixel and line buffer layout
    localparam int PIX_W   = 24;
    localparam int LB_ROWS = 4;
    localparam int LB_W    = PIX_W * LB_ROWS;
    localparam int KSIZE   = 5;
    localparam int SUM_W   = 18;

    typedef logic [PIX_W-1:0] t_pix;

    // Per-transaction tap control handed to the filter datapath
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             sharpen;
        logic [KSIZE-1:0] row_ok;
        logic [KSIZE-1:0] col_ok;
    } t_tap_ctl;

    // Registered signed channel sums
    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic [2:0][SUM_W-1:0]       sum;
    } t_sum;

    // Binomial row weight 1,4,6,4,1
    function automatic logic [2:0] gauss_w(input logic [2:0] n);
        logic [2:0] w;
        case (n)
            3'd0:    w = 3'd1;
            3'd1:    w = 3'd4;
            3'd2:    w = 3'd6;
            3'd3:    w = 3'd4;
            3'd4:    w = 3'd1;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rkc_if.sv
`default_nettype none

// Input pixel channel
interface rkc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       flush;
    modport source (output valid, in_red, in_green, in_blue, flush, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

// Filtered pixel channel
interface rkc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// Kernel select write channel
interface rkc_cfg_if;
    logic valid;
    logic ready;
    logic kernel_select;
    modport source (output valid, kernel_select, input ready);
    modport sink   (input valid, kernel_select, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rkc_ram.sv
`default_nettype none

module rkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; read data hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rkc_filt.sv
`default_nettype none

module rkc_filt import rkc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_tap_ctl i_ctl,
    input  wire t_pix     i_win [KSIZE][KSIZE],
    output t_sum          o_sum
);

    logic [2:0][11:0]      n_h [KSIZE];
    logic [2:0][11:0]      r_h [KSIZE];
    logic [2:0][7:0]       n_cen;
    logic [2:0][7:0]       r_cen;
    logic [2:0][9:0]       n_cross;
    logic [2:0][9:0]       r_cross;
    logic                  r_valid;
    logic                  r_last;
    logic                  r_sharp;
    logic [2:0][SUM_W-1:0] n_sum;

    // Mask taps outside the frame, form row sums and the sharpen cross
    always_comb begin
        logic [7:0] m [KSIZE][KSIZE];
        for (int a = 0; a < KSIZE; a++) begin
            for (int k = 0; k < KSIZE; k++) begin
                m[a][k] = 8'd0;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int a = 0; a < KSIZE; a++) begin
                for (int k = 0; k < KSIZE; k++) begin
                    m[a][k] = (i_ctl.row_ok[a] && i_ctl.col_ok[k]) ?
                              i_win[k][a][8*ch +: 8] : 8'd0;
                end
                n_h[a][ch] = 12'd0;
                for (int k = 0; k < KSIZE; k++) begin
                    n_h[a][ch] = n_h[a][ch] + 12'(m[a][k]) * 12'(gauss_w(3'(k)));
                end
            end
            n_cen[ch]   = m[3][1];
            n_cross[ch] = 10'(m[2][1]) + 10'(m[4][1]) + 10'(m[3][0]) + 10'(m[3][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h     <= n_h;
            r_cen   <= n_cen;
            r_cross <= n_cross;
            r_last  <= i_ctl.last;
            r_sharp <= i_ctl.sharpen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Combine rows for the blur or center and cross for the sharpen
    always_comb begin
        logic [15:0] g;
        for (int ch = 0; ch < 3; ch++) begin
            g = 16'd0;
            for (int a = 0; a < KSIZE; a++) begin
                g = g + 16'(r_h[a][ch]) * 16'(gauss_w(3'(a)));
            end
            if (r_sharp) begin
                n_sum[ch] = {2'b00, r_cen[ch], 8'd0} - {4'b0000, r_cross[ch], 4'd0};
            end else begin
                n_sum[ch] = {2'b00, g};
            end
        end
    end

    // Register the sums; only the valid flag is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_sum.valid <= 1'b0;
        end else if (i_en) begin
            o_sum.valid <= r_valid;
        end
        if (i_en) begin
            o_sum.sum  <= n_sum;
            o_sum.last <= r_last;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_kernel_convolution_top.sv
`default_nettype none

// RGB streaming convolution, 5x5 blur or 3x3 sharpen.
// i_pix carries raster-order pixels (flush marks a pixel-less transaction);
// o_res carries filtered pixels, frame_end on the last one of a frame.
// i_cfg writes kernel_select; it is sampled on the first transaction of a
// frame and holds for the whole frame. i_cfg is always ready.
// A frame of W x H pixels needs c*W + c further transactions after its last
// pixel (c = 2 for blur, 1 for sharpen) to push out the final results.
// One transaction is taken per clock while the receiver does not stall. A result
// leaves after the transaction that completes its window, through line buffer
// read, window shift, row sums, kernel sum and rounding into the output register.
// The four previous rows live in one 512 x 96 RAM, read and written back
// per column, so each column position is touched once per line.
// When the receiver stalls, the whole pipeline and i_pix.ready hold.
// Reset clears the position counters, the pipeline valids and the kernel
// select; no line buffer clearing pass is needed.
module rgb_kernel_convolution_top import rkc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rkc_pix_if.sink    i_pix,
    rkc_cfg_if.sink    i_cfg,
    rkc_res_if.source  o_res
);

    logic              en;
    logic              acc;
    logic              r_kernel_sel;
    logic              r_frame_sharp;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_oj, n_oj;
    logic [OROW_W-1:0] r_oi, n_oi;
    logic              n_frame_sharp;
    logic              cur_sharp;
    logic              produce;
    logic              last;
    t_pix              in_pix;

    logic              r_s1_valid;
    t_pix              r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_prod;
    logic              r_s1_last;
    logic              r_s1_sharp;
    logic [COL_W-1:0]  r_s1_oj;
    logic [OROW_W-1:0] r_s1_oi;

    logic [LB_W-1:0]   ram_q;
    t_pix              newcol [KSIZE];
    t_pix              r_win [KSIZE][KSIZE];
    t_tap_ctl          n_ctl, r_ctl;
    t_sum              sum;

    logic              r_out_valid;
    logic [2:0][7:0]   r_out;
    logic              r_out_last;
    logic [2:0][7:0]   n_out;

    assign en          = !r_out_valid || o_res.ready;
    assign acc         = i_pix.valid && en;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    // Hold the kernel select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_sel <= 1'b0;
        end else if (i_cfg.valid) begin
            r_kernel_sel <= i_cfg.kernel_select;
        end
    end

    // Track input and output positions
    always_comb begin
        logic [ROW_W-1:0] c;
        cur_sharp = (r_col == '0 && r_row == '0) ? r_kernel_sel : r_frame_sharp;
        c         = cur_sharp ? ROW_W'(1) : ROW_W'(2);
        produce   = (r_row > c) || (r_row == c && r_col >= COL_W'(c));
        last      = produce && r_oi == OROW_W'(IMAGE_HEIGHT - 1) &&
                    r_oj == COL_W'(IMAGE_WIDTH - 1);
        in_pix    = (i_pix.flush || r_row >= ROW_W'(IMAGE_HEIGHT)) ? '0 :
                    {i_pix.in_blue, i_pix.in_green, i_pix.in_red};
        n_frame_sharp = cur_sharp;
        n_col = r_col;
        n_row = r_row;
        n_oi  = r_oi;
        n_oj  = r_oj;
        if (last) begin
            n_col = '0;
            n_row = '0;
            n_oi  = '0;
            n_oj  = '0;
        end else begin
            if (r_col == COL_W'(IMAGE_WIDTH - 1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (produce) begin
                if (r_oj == COL_W'(IMAGE_WIDTH - 1)) begin
                    n_oj = '0;
                    n_oi = r_oi + OROW_W'(1);
                end else begin
                    n_oj = r_oj + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_oi          <= '0;
            r_oj          <= '0;
            r_frame_sharp <= 1'b0;
        end else if (acc) begin
            r_col         <= n_col;
            r_row         <= n_row;
            r_oi          <= n_oi;
            r_oj          <= n_oj;
            r_frame_sharp <= n_frame_sharp;
        end
    end

    // Stage 1: line buffer read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix   <= in_pix;
            r_s1_col   <= r_col;
            r_s1_prod  <= produce;
            r_s1_last  <= last;
            r_s1_sharp <= cur_sharp;
            r_s1_oi    <= r_oi;
            r_s1_oj    <= r_oj;
        end
    end

    // Column of four previous rows, newest in the low word
    rkc_ram #(
        .WIDTH (LB_W),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && en),
        .i_waddr (r_s1_col),
        .i_wdata ({ram_q[LB_W-PIX_W-1:0], r_s1_pix}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // Stack the column: oldest row first
    always_comb begin
        for (int a = 0; a < LB_ROWS; a++) begin
            newcol[a] = ram_q[PIX_W*(LB_ROWS-1-a) +: PIX_W];
        end
        newcol[KSIZE-1] = r_s1_pix;
    end

    // Shift the window by one column per transaction
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && en) begin
            r_win[0] <= newcol;
            for (int k = 1; k < KSIZE; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // Frame masks for the window rows and columns
    always_comb begin
        logic [YW-1:0] ys;
        logic [XW-1:0] xs;
        n_ctl.valid   = r_s1_valid && r_s1_prod;
        n_ctl.last    = r_s1_last;
        n_ctl.sharpen = r_s1_sharp;
        xs = XW'(r_s1_oj) + (r_s1_sharp ? XW'(1) : XW'(2));
        for (int a = 0; a < KSIZE; a++) begin
            ys = YW'(r_s1_oi) + YW'(a) + (r_s1_sharp ? YW'(1) : YW'(2));
            n_ctl.row_ok[a] = (ys >= YW'(4)) && (ys < YW'(IMAGE_HEIGHT + 4));
            n_ctl.col_ok[a] = (xs >= XW'(a)) && (xs < XW'(IMAGE_WIDTH + a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (en) begin
            r_ctl <= n_ctl;
        end
    end

    rkc_filt u_filt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_ctl),
        .i_win   (r_win),
        .o_sum   (sum)
    );

    // Round magnitude and saturate
    always_comb begin
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rnd;
        for (int ch = 0; ch < 3; ch++) begin
            mag = sum.sum[ch][SUM_W-1] ? (~sum.sum[ch] + SUM_W'(1)) : sum.sum[ch];
            rnd = (mag + SUM_W'(128)) >> 8;
            n_out[ch] = (rnd > SUM_W'(255)) ? 8'hFF : rnd[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sum.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out      <= n_out;
            r_out_last <= sum.last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = r_out[0];
    assign o_res.out_green = r_out[1];
    assign o_res.out_blue  = r_out[2];
    assign o_res.frame_end = r_out_last;

endmodule

`default_nettype wire

FILE: tb/tb_rgb_kernel_convolution_top.sv
`timescale 1ns / 100ps

module tb_rgb_kernel_convolution_top;
    import rkc_pkg::*;

    localparam int FRAME_PIX = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int DRAIN_CYCLES = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_rgb_out;

    // Filter predictor and queue of pending filtered pixels
    class conv_scoreboard;
        t_rgb_out   pending_px[$];
        logic [23:0] rows[5*IMAGE_WIDTH];
        int  col_cnt, row_cnt, pos;
        bit  kernel_reg, frame_sharpen;
        int  frames_done;
        int  errors;

        function void clear();
            foreach (rows[k]) rows[k] = '0;
            col_cnt = 0;
            row_cnt = 0;
            pos = 0;
            kernel_reg = 0;
            frame_sharpen = 0;
            frames_done = 0;
            errors = 0;
        endfunction

        function int tap_gain(bit sharp, int ky, int kx);
            int g[5];
            g = '{1, 4, 6, 4, 1};
            if (sharp) begin
                if (ky == 1 && kx == 1) return 256;
                if (ky == 1 || kx == 1) return -16;
                return 0;
            end
            return g[ky] * g[kx];
        endfunction

        function logic [7:0] round_sat(int acc);
            int mag;
            mag = (acc < 0) ? -acc : acc;
            mag = (mag + 128) >>> 8;
            return (mag > 255) ? 8'd255 : mag[7:0];
        endfunction

        function void note_input(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
            int rad, lag, q, oi, oj, y, x, w;
            int acc[3];
            logic [23:0] px;
            t_rgb_out o;
            if (pos == 0) frame_sharpen = kernel_reg;
            rad = frame_sharpen ? 1 : 2;
            lag = rad * IMAGE_WIDTH + rad;
            // store the pixel, black on a flush
            if (row_cnt < IMAGE_HEIGHT && col_cnt < IMAGE_WIDTH)
                rows[(row_cnt % 5) * IMAGE_WIDTH + col_cnt] = fl ? 24'h0 : {b, g, r};
            if (pos >= lag) begin
                q = pos - lag;
                oi = q / IMAGE_WIDTH;
                oj = q % IMAGE_WIDTH;
                acc = '{0, 0, 0};
                for (int dy = -rad; dy <= rad; dy++) begin
                    for (int dx = -rad; dx <= rad; dx++) begin
                        y = oi + dy;
                        x = oj + dx;
                        w = tap_gain(frame_sharpen, rad - dy, rad - dx);
                        px = '0;
                        if (y >= 0 && y < IMAGE_HEIGHT && x >= 0 && x < IMAGE_WIDTH)
                            px = rows[(y % 5) * IMAGE_WIDTH + x];
                        for (int ch = 0; ch < 3; ch++)
                            acc[ch] += int'(px[8*ch +: 8]) * w;
                    end
                end
                o.red = round_sat(acc[0]);
                o.green = round_sat(acc[1]);
                o.blue = round_sat(acc[2]);
                o.frame_end = (q == FRAME_PIX - 1);
                pending_px.push_back(o);
                // restart the position after the frame's last result
                if (q >= FRAME_PIX - 1) begin
                    pos = 0;
                    col_cnt = 0;
                    row_cnt = 0;
                    frames_done++;
                    return;
                end
            end
            pos++;
            col_cnt++;
            if (col_cnt >= IMAGE_WIDTH) begin
                col_cnt = 0;
                row_cnt++;
            end
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
            t_rgb_out e;
            if (pending_px.size() == 0) begin
                $error("unexpected result r=%0d g=%0d b=%0d fe=%0b", r, g, b, fe);
                errors++;
                return;
            end
            e = pending_px.pop_front();
            if (r !== e.red) begin
                $error("out_red expected %0d actual %0d", e.red, r);
                errors++;
            end
            if (g !== e.green) begin
                $error("out_green expected %0d actual %0d", e.green, g);
                errors++;
            end
            if (b !== e.blue) begin
                $error("out_blue expected %0d actual %0d", e.blue, b);
                errors++;
            end
            if (fe !== e.frame_end) begin
                $error("frame_end expected %0b actual %0b", e.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    longint cycle_cnt;
    int     src_idle_pct;
    int     snk_idle_pct;
    conv_scoreboard conv_sb;

    rkc_pix_if pix();
    rkc_cfg_if cfg();
    rkc_res_if res();

    rgb_kernel_convolution_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    initial begin
        i_clk = 1'b0;
        pix.valid = 1'b0;
        pix.in_red = '0;
        pix.in_green = '0;
        pix.in_blue = '0;
        pix.flush = 1'b0;
        cfg.valid = 1'b0;
        cfg.kernel_select = 1'b0;
        res.ready = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cycle_cnt = 0;
        conv_sb = new();
        conv_sb.clear();
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL rgb_kernel_convolution_top");
            $finish;
        end
    end

    // Receiver: random stalls, check each accepted result
    always @(negedge i_clk) begin
        if (i_rst_n)
            res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            conv_sb.check_result(res.out_red, res.out_green, res.out_blue, res.frame_end);
    end

    // Drive one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid = 1'b0;
            @(negedge i_clk);
        end
        pix.in_red = r;
        pix.in_green = g;
        pix.in_blue = b;
        pix.flush = fl;
        pix.valid = 1'b1;
        do @(posedge i_clk); while (!pix.ready);
        conv_sb.note_input(r, g, b, fl);
        @(negedge i_clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] ch[3];
        int pick;
        for (int k = 0; k < 3; k++) begin
            pick = $urandom_range(9);
            ch[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end
        send_pixel(ch[0], ch[1], ch[2], $urandom_range(9) == 0);
    endtask

    // Hold the sender until every expected result is out, then let the pipe settle
    task automatic wait_drained();
        pix.valid = 1'b0;
        while (conv_sb.pending_px.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_kernel(bit sel);
        wait_drained();
        cfg.kernel_select = sel;
        cfg.valid = 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        conv_sb.kernel_reg = sel;
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Blur frame: directed start, then random under both idle mixes
        write_kernel(1'b0);
        src_idle_pct = 25;
        snk_idle_pct = 65;
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h01, 8'h80, 8'h7F, 1'b0);
        for (int k = 0; k < 12; k++)
            send_pixel(8'hFF, 8'hFF, 8'hFF, k[0]);
        for (int k = 0; k < 600; k++)
            send_random_pixel();
        wait_drained();
        src_idle_pct = 65;
        snk_idle_pct = 25;
        for (int k = 0; k < 400; k++)
            send_random_pixel();

        // Kernel change mid-frame must not affect the running frame
        write_kernel(1'b1);

        // Continue the frame under all idle mixes
        src_idle_pct = 25;
        snk_idle_pct = 65;
        for (int k = 0; k < 300; k++)
            send_random_pixel();
        src_idle_pct = 65;
        snk_idle_pct = 25;
        for (int k = 0; k < 300; k++)
            send_random_pixel();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int k = 0; k < 280; k++)
            send_random_pixel();
        write_kernel(1'b0);

        wait_drained();
        if (conv_sb.errors == 0)
            $display("PASS rgb_kernel_convolution_top");
        else
            $display("FAIL rgb_kernel_convolution_top");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rkc_pkg.sv
hw/rtl/rkc_if.sv
hw/rtl/rkc_ram.sv
hw/rtl/rkc_filt.sv
hw/rtl/rgb_kernel_convolution_top.sv
tb/tb_rgb_kernel_convolution_top.sv
